[src/bmpx_pkg.sv]
// Package for the bitmap pixel expander: format codes, register indexes,
// input kinds and the stage record passed from the byte assembler to the top.
// No dependencies.
package bmpx_pkg;

    localparam int unsigned REG_W = 13;   // widest configuration register

    // source pixel formats
    localparam logic [1:0] FMT_PAL8  = 2'd0;
    localparam logic [1:0] FMT_RGB16 = 2'd1;
    localparam logic [1:0] FMT_RGB24 = 2'd2;
    localparam logic [1:0] FMT_RGB32 = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // item kinds carried in tuser
    localparam logic OP_PIXEL   = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    // one completed pixel on its way to the result register
    typedef struct packed {
        logic       lookup;   // take bytes 0..2 from the palette read
        logic       oob;      // lookup index beyond the palette
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic       eoi;      // last pixel of the frame
    } t_stage;

endpackage

[src/bmpx_palette.sv]
// Palette memory of the bitmap pixel expander: one write port, one read
// port with registered read data. Uses bmpx_pkg.
module bmpx_palette #(
    parameter int unsigned ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_we,
    input  logic [7:0]  i_waddr,
    input  logic [23:0] i_wdata,
    input  logic        i_re,
    input  logic [7:0]  i_raddr,
    output logic [23:0] o_rdata
);
    import bmpx_pkg::*;

    localparam int unsigned IDX_W = $clog2(ENTRIES);

    logic [23:0] r_mem [ENTRIES];
    logic [23:0] r_q;

    // drop writes beyond the palette
    always_ff @(posedge i_clk) begin
        if (i_we && ({1'b0, i_waddr} < 9'(ENTRIES))) begin
            r_mem[i_waddr[IDX_W-1:0]] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr[IDX_W-1:0]];
        end
    end

    assign o_rdata = r_q;

endmodule

[src/bmpx_assemble.sv]
// Byte assembler of the bitmap pixel expander: byte phase, partial pixel
// and frame pixel counter; forms the stage record of a completed pixel.
// Uses bmpx_pkg.
module bmpx_assemble #(
    parameter int unsigned CNT_W       = 24,
    parameter int unsigned PAL_ENTRIES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_restart,   // configuration write
    input  logic                i_byte_vld,  // pixel byte accepted
    input  logic [7:0]          i_byte,
    input  logic [1:0]          i_fmt,
    input  logic [CNT_W-1:0]    i_last_idx,  // frame size minus one
    output logic                o_done,      // byte completes a pixel
    output bmpx_pkg::t_stage    o_stage
);
    import bmpx_pkg::*;

    logic [1:0]       r_phase,   n_phase;
    logic [23:0]      r_partial, n_partial;
    logic [CNT_W-1:0] r_cnt,     n_cnt;
    logic [15:0]      w16;

    assign w16 = {i_byte, r_partial[7:0]};

    always_comb begin
        n_phase   = r_phase;
        n_partial = r_partial;
        n_cnt     = r_cnt;
        o_done    = 1'b0;

        o_stage        = '0;
        o_stage.lookup = (i_fmt == FMT_PAL8);
        o_stage.oob    = ({1'b0, i_byte} >= 9'(PAL_ENTRIES));
        o_stage.eoi    = (r_cnt >= i_last_idx);
        case (i_fmt)
            FMT_RGB16: begin
                o_stage.b0 = {w16[4:0], 3'b000};
                o_stage.b1 = {w16[10:5], 2'b00};
                o_stage.b2 = {w16[15:11], 3'b000};
            end
            FMT_RGB24: begin
                o_stage.b0 = r_partial[7:0];
                o_stage.b1 = r_partial[15:8];
                o_stage.b2 = i_byte;
            end
            FMT_RGB32: begin
                o_stage.b0 = r_partial[23:16];
                o_stage.b1 = r_partial[15:8];
                o_stage.b2 = r_partial[7:0];
                o_stage.b3 = i_byte;
            end
            default: begin
                // palette format: bytes come from the memory read
            end
        endcase

        if (i_restart) begin
            n_phase   = '0;
            n_partial = '0;
            n_cnt     = '0;
        end else if (i_byte_vld) begin
            if (r_phase < i_fmt) begin
                case (r_phase)
                    2'd0:    n_partial[7:0]   = i_byte;
                    2'd1:    n_partial[15:8]  = i_byte;
                    default: n_partial[23:16] = i_byte;
                endcase
                n_phase = r_phase + 2'd1;
            end else begin
                o_done    = 1'b1;
                n_phase   = '0;
                n_partial = '0;
                n_cnt     = o_stage.eoi ? '0 : r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_partial <= '0;
            r_cnt     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_partial <= n_partial;
            r_cnt     <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_cnt_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= i_last_idx || $past(i_restart) || i_restart)
        else $error("pixel counter beyond frame");
`endif

endmodule

[src/bmp_pixel_expander_core.sv]
// Top level of the bitmap pixel expander: configuration registers, input
// stage, palette read and result register. Uses bmpx_pkg, bmpx_palette and
// bmpx_assemble.
//
// Usage:
//   Input stream (s_axis_*): one item per handshake. tuser is the kind:
//   pixel byte or palette write. A palette write stores r,g,b at the given
//   index and yields nothing. Pixel bytes are gathered per the configured
//   format (1..4 bytes per pixel); the byte that completes a pixel yields
//   one 32-bit result on m_axis_*, with tlast on the last pixel of
//   width times height, after which the frame count starts over.
//   A completing byte is registered in the input stage with its palette
//   read, then moves into the result register once that is free.
//   Throughput: one input item every cycle unless the receiver stalls;
//   the two registered stages and one palette read port set this figure.
//   Receiver stall: the result register holds, the input stage fills, and
//   s_axis_tready falls only when both are full.
//   Reset (synchronous, active low): empties both stages, restarts the
//   frame, format 24 bpp, width and height 1; palette content stays
//   undefined until written. Any configuration write also restarts the
//   frame; write configuration only while the block is idle.
module bmp_pixel_expander_core #(
    parameter int unsigned PALETTE_ENTRIES = 256,
    parameter int unsigned MAX_DIMENSION   = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [bmpx_pkg::REG_W-1:0]   i_cfg_wdata,
    // input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata: data_byte[7:0], palette_index[15:8], palette_red[23:16],
    //        palette_green[31:24], palette_blue[39:32]
    input  logic [39:0]                  s_axis_tdata,
    // tuser: operation[0]
    input  logic                         s_axis_tuser,
    // output stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // tdata: out_byte0[7:0], out_byte1[15:8], out_byte2[23:16],
    //        out_byte3[31:24]
    output logic [31:0]                  m_axis_tdata,
    // tlast: end_of_image
    output logic                         m_axis_tlast
);
    import bmpx_pkg::*;

    // effective dimension limit, also bounded by the register width
    localparam longint DIM_LIM   = (MAX_DIMENSION < 8191) ? MAX_DIMENSION : 8191;
    localparam longint FRAME_MAX = DIM_LIM * DIM_LIM;
    localparam int unsigned CNT_W = $clog2(FRAME_MAX);

    function automatic logic [REG_W-1:0] f_clamp(input logic [REG_W-1:0] v);
        logic [REG_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = REG_W'(1);
        end else if ({19'd0, v} > 32'(DIM_LIM)) begin
            res = REG_W'(DIM_LIM);
        end
        return res;
    endfunction

    // ---------------- configuration ----------------
    logic [1:0]       r_fmt;
    logic [REG_W-1:0] r_width, r_height;       // clamped dimensions
    logic [CNT_W-1:0] r_last_idx;              // frame size minus one
    logic             cfg_hit;
    logic [REG_W-1:0] cfg_clamped;
    logic [2*REG_W-1:0] cfg_prod;

    assign cfg_hit = i_cfg_we && (i_cfg_index == REG_FORMAT ||
                                  i_cfg_index == REG_WIDTH ||
                                  i_cfg_index == REG_HEIGHT);
    assign cfg_clamped = f_clamp(i_cfg_wdata);

    // new frame size from the written dimension and the held one
    always_comb begin
        case (i_cfg_index)
            REG_WIDTH:  cfg_prod = cfg_clamped * r_height;
            REG_HEIGHT: cfg_prod = r_width * cfg_clamped;
            default:    cfg_prod = r_width * r_height;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt      <= FMT_RGB24;
            r_width    <= REG_W'(1);
            r_height   <= REG_W'(1);
            r_last_idx <= '0;
        end else if (cfg_hit) begin
            case (i_cfg_index)
                REG_FORMAT: r_fmt    <= i_cfg_wdata[1:0];
                REG_WIDTH:  r_width  <= cfg_clamped;
                REG_HEIGHT: r_height <= cfg_clamped;
                default: begin
                end
            endcase
            r_last_idx <= CNT_W'(cfg_prod - (2*REG_W)'(1));
        end
    end

    // ---------------- handshake ----------------
    logic r_a_valid, r_o_valid;
    logic a_adv;        // input stage may move into the result register
    logic in_acc;
    logic pix_acc;
    logic pal_acc;

    assign a_adv         = !r_o_valid || m_axis_tready;
    assign s_axis_tready = !r_a_valid || a_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign pix_acc       = in_acc && (s_axis_tuser == OP_PIXEL);
    assign pal_acc       = in_acc && (s_axis_tuser == OP_PALETTE);

    // ---------------- byte assembly ----------------
    logic   done;
    t_stage stage_in;

    bmpx_assemble #(
        .CNT_W       (CNT_W),
        .PAL_ENTRIES (PALETTE_ENTRIES)
    ) u_assemble (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (cfg_hit),
        .i_byte_vld (pix_acc),
        .i_byte     (s_axis_tdata[7:0]),
        .i_fmt      (r_fmt),
        .i_last_idx (r_last_idx),
        .o_done     (done),
        .o_stage    (stage_in)
    );

    // ---------------- palette ----------------
    logic [23:0] pal_q;

    // read only when a palette pixel enters the input stage; the read data
    // then holds as long as that stage holds
    bmpx_palette #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_acc),
        .i_waddr (s_axis_tdata[15:8]),
        .i_wdata (s_axis_tdata[39:16]),
        .i_re    (done && stage_in.lookup),
        .i_raddr (s_axis_tdata[7:0]),
        .o_rdata (pal_q)
    );

    // ---------------- input stage ----------------
    t_stage r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_a_valid <= done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_a <= stage_in;
        end
    end

    // ---------------- result register ----------------
    logic [31:0] n_o_data;
    logic [31:0] r_o_data;
    logic        r_o_last;

    // palette pixel: red, green, blue, zero; unknown index gives black
    // (the entry holds blue in its top byte and red in its bottom byte)
    always_comb begin
        n_o_data = {r_a.b3, r_a.b2, r_a.b1, r_a.b0};
        if (r_a.lookup) begin
            n_o_data = r_a.oob ? 32'd0 : {8'd0, pal_q[23:16], pal_q[15:8], pal_q[7:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_adv) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv && r_a_valid) begin
            r_o_data <= n_o_data;
            r_o_last <= r_a.eoi;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_a_valid && !r_o_valid)
        else $error("pipeline not empty after reset");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !a_adv |=> r_a_valid && $stable(r_a))
        else $error("input stage lost an item while stalled");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_a_valid && r_o_valid && !m_axis_tready)
        else $error("input refused while room remains");
`endif

endmodule
